FILE: design/maxr_pkg.sv
package maxr_pkg;

    // parameter defaults
    localparam int FREE_MAX_DEF   = 64;
    localparam int PLACED_MAX_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    // fixed field widths
    localparam int DIM_W    = 13;
    localparam int POS_W    = 12;
    localparam int STATUS_W = 2;

    localparam logic [DIM_W-1:0] BIN_RESET = 13'd4096;

    // score bonus per left-touching neighbor
    localparam int BONUS_STEP = 2;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    // register indexes
    localparam logic REG_BIN_WIDTH  = 1'b0;
    localparam logic REG_BIN_HEIGHT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SC_HEAD,
        S_SC_SCAN,
        S_SC_END,
        S_SPL_A,
        S_SPL_B,
        S_PR_FETCH,
        S_PR_WAIT,
        S_PR_SCAN,
        S_LD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic shift;
        logic set;
    } cell_ctl_t;

endpackage

FILE: design/maxr_ram.sv
module maxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/maxr_cell.sv
module maxr_cell #(
    parameter int W = 52,
    parameter logic [W-1:0] RST_VAL = '0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  maxr_pkg::cell_ctl_t ctl,
    input  logic [W-1:0]        shift_in,
    input  logic [W-1:0]        set_val,
    output logic [W-1:0]        q
);

    import maxr_pkg::*;

    logic [W-1:0] q_reg;

    // set wins over shift; only the head cell ever sees set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RST_VAL;
        end
        else if (ctl.set)
        begin
            q_reg <= set_val;
        end
        else if (ctl.shift)
        begin
            q_reg <= shift_in;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/maxrects_rectangle_placer.sv
// Rectangle placer, max-rects style, one result beat per input beat.
// Start, no-fit on zero size and full placed table go from idle straight to finish.
// A placement scans every free entry, and the placed list for each fitting entry when
// that list is not empty, splits overlapped entries, prunes enclosed pieces and reloads
// the chain; one item in flight, the next is taken on return to idle.
// Reset: free list holds the whole default bin, placed list empty, no beat out.
module maxrects_rectangle_placer
    #(
    parameter int FREE_MAX   = maxr_pkg::FREE_MAX_DEF,
    parameter int PLACED_MAX = maxr_pkg::PLACED_MAX_DEF,
    parameter int COORD_BITS = maxr_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [maxr_pkg::DIM_W-1:0]    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [maxr_pkg::DIM_W-1:0]    rect_width,
    input  logic [maxr_pkg::DIM_W-1:0]    rect_height,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [maxr_pkg::POS_W-1:0]    placed_x,
    output logic [maxr_pkg::POS_W-1:0]    placed_y,
    output logic [maxr_pkg::STATUS_W-1:0] status
);

    import maxr_pkg::*;

    // coordinate and rect widths; a rect is {x, y, w, h}
    localparam int DW   = COORD_BITS + 1;
    localparam int RW   = 4 * DW;
    localparam int SUMW = DW + 1;
    localparam int SW   = DW + 3;
    localparam int BIG  = ((DW > DIM_W) ? DW : DIM_W) + 1;
    // list sizes
    localparam int FCW  = $clog2(FREE_MAX + 1);
    localparam int SD   = 4 * FREE_MAX;
    localparam int SAW  = $clog2(SD);
    localparam int NW   = $clog2(SD + 1);
    localparam int PAW  = $clog2(PLACED_MAX);
    localparam int PCW  = $clog2(PLACED_MAX + 1);
    localparam int BW   = $clog2(BONUS_STEP * PLACED_MAX + 1);
    localparam int SCW  = DW + BW + 1;

    // whole-bin entry after reset, default bin clamped to the coordinate range
    localparam logic [DW-1:0] RST_DIM =
        (COORD_BITS >= 12) ? DW'(4096) : DW'(1 << COORD_BITS);
    localparam logic [RW-1:0] CELL0_RST = {DW'(0), DW'(0), RST_DIM, RST_DIM};

    function automatic logic [DW-1:0] fx(input logic [RW-1:0] r);
        return r[4*DW-1 -: DW];
    endfunction
    function automatic logic [DW-1:0] fy(input logic [RW-1:0] r);
        return r[3*DW-1 -: DW];
    endfunction
    function automatic logic [DW-1:0] fw(input logic [RW-1:0] r);
        return r[2*DW-1 -: DW];
    endfunction
    function automatic logic [DW-1:0] fh(input logic [RW-1:0] r);
        return r[DW-1 -: DW];
    endfunction

    // bin side above 2^COORD_BITS saturates
    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [BIG-1:0] ve;
        logic [BIG-1:0] lim;
        ve  = BIG'(v);
        lim = BIG'(1) << COORD_BITS;
        return DW'((ve > lim) ? lim : ve);
    endfunction

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [DIM_W-1:0]      bin_width_reg, bin_height_reg;
    logic [NW-1:0]         i_reg, i_next;
    logic [PCW-1:0]        j_reg, j_next;
    logic                  pend_reg, pend_next;
    logic                  live_reg, live_next;
    logic [BW-1:0]         bonus_reg, bonus_next;
    logic signed [SCW-1:0] best_reg, best_next;
    logic                  best_bonus_reg, best_bonus_next;
    logic                  found_reg, found_next;
    logic [RW-1:0]         pick_reg, pick_next;
    logic [RW-1:0]         g_reg, g_next;
    logic [DIM_W-1:0]      w_reg, w_next;
    logic [DIM_W-1:0]      h_reg, h_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         k_reg, k_next;
    logic [NW-1:0]         m_reg, m_next;
    logic [1:0]            pc_reg, pc_next;
    logic                  killed_reg, killed_next;
    logic [RW-1:0]         cand_reg, cand_next;
    logic [FCW-1:0]        free_count_reg, free_count_next;
    logic [PCW-1:0]        placed_count_reg, placed_count_next;
    logic [POS_W-1:0]      res_x_reg, res_x_next;
    logic [POS_W-1:0]      res_y_reg, res_y_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      out_x_reg, out_x_next;
    logic [POS_W-1:0]      out_y_reg, out_y_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    //------------------------------------------------------------------
    // free list: a chain of cells, head at cell 0, shifting toward it.
    // A full pass of FREE_MAX shifts walks every entry and restores order.
    //------------------------------------------------------------------
    logic          chain_shift;
    logic          chain_set;
    logic          chain_load;
    logic [RW-1:0] load_val;
    logic [RW-1:0] tail_in;
    logic [RW-1:0] bin_rect;
    logic [RW-1:0] cell_q [FREE_MAX];
    logic [RW-1:0] head;

    assign head     = cell_q[0];
    assign tail_in  = chain_load ? load_val : cell_q[0];
    assign bin_rect = {DW'(0), DW'(0), clamp_dim(bin_width_reg), clamp_dim(bin_height_reg)};

    for (genvar gi = 0; gi < FREE_MAX; gi++)
    begin : g_cell
        cell_ctl_t ctl;
        logic [RW-1:0] nb;

        assign ctl.shift = chain_shift;
        assign ctl.set   = chain_set && (gi == 0);

        if (gi == FREE_MAX - 1)
        begin : g_tail
            assign nb = tail_in;
        end
        else
        begin : g_mid
            assign nb = cell_q[gi+1];
        end

        maxr_cell #(
            .W       (RW),
            .RST_VAL ((gi == 0) ? CELL0_RST : RW'(0))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .shift_in (nb),
            .set_val  (bin_rect),
            .q        (cell_q[gi])
        );
    end

    //------------------------------------------------------------------
    // memories: placed list, split scratch, pruned survivors
    //------------------------------------------------------------------
    logic          p_we;
    logic [RW-1:0] p_rdata;
    logic [RW-1:0] g_new;
    logic          sc_we;
    logic [RW-1:0] sc_wdata;
    logic [RW-1:0] sc_rdata;
    logic          sv_we;
    logic [RW-1:0] sv_rdata;

    maxr_ram #(.WIDTH(RW), .DEPTH(PLACED_MAX)) u_placed (
        .clk   (clk),
        .we    (p_we),
        .waddr (placed_count_reg[PAW-1:0]),
        .wdata (g_new),
        .raddr (j_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    maxr_ram #(.WIDTH(RW), .DEPTH(SD)) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (n_reg[SAW-1:0]),
        .wdata (sc_wdata),
        .raddr (i_reg[SAW-1:0]),
        .rdata (sc_rdata)
    );

    maxr_ram #(.WIDTH(RW), .DEPTH(SD)) u_surv (
        .clk   (clk),
        .we    (sv_we),
        .waddr (k_reg[SAW-1:0]),
        .wdata (cand_reg),
        .raddr (m_reg[SAW-1:0]),
        .rdata (sv_rdata)
    );

    //------------------------------------------------------------------
    // datapath
    //------------------------------------------------------------------
    logic [DW-1:0] h_x, h_y, h_w, h_h;
    logic [DW-1:0] p_x, p_y, p_w, p_h;
    logic [DW-1:0] g_x, g_y, g_w, g_h;
    logic [DW-1:0] k_x, k_y, k_w, k_h;
    logic [DW-1:0] a_x, a_y, a_w, a_h;
    logic [DW-1:0] b_x, b_y, b_w, b_h;
    logic [DW-1:0] new_x;
    logic          in_acc;
    logic          active;
    logic          fits;
    logic          at_end;
    logic          scan_issue;
    logic          sv_issue;
    logic          ld_issue;
    logic signed [SW-1:0] dy, dd, ad;
    logic [DW-1:0] mh;
    logic          bonus_hit;
    logic [BW-1:0] cur_bonus;
    logic signed [SCW-1:0] score_now;
    logic          better;
    logic          ovl;
    logic          encl;
    logic [3:0]    piece_ok;
    logic [RW-1:0] piece_val [4];
    logic [SUMW-1:0] f_r, f_b, g_r, g_b;

    assign in_acc = in_valid && !in_stall;

    assign h_x = fx(head);
    assign h_y = fy(head);
    assign h_w = fw(head);
    assign h_h = fh(head);
    assign p_x = fx(p_rdata);
    assign p_y = fy(p_rdata);
    assign p_w = fw(p_rdata);
    assign p_h = fh(p_rdata);
    assign g_x = fx(g_reg);
    assign g_y = fy(g_reg);
    assign g_w = fw(g_reg);
    assign g_h = fh(g_reg);
    assign k_x = fx(pick_reg);
    assign k_y = fy(pick_reg);
    assign k_w = fw(pick_reg);
    assign k_h = fh(pick_reg);

    assign active = i_reg < NW'(free_count_reg);
    assign at_end = i_reg == NW'(FREE_MAX);
    assign fits   = (BIG'(h_w) >= BIG'(w_reg)) && (BIG'(h_h) >= BIG'(h_reg));

    assign scan_issue = j_reg < placed_count_reg;
    assign sv_issue   = (m_reg < k_reg) && !killed_reg;
    assign ld_issue   = m_reg < NW'(FREE_MAX);

    // neighbor test: placed right edge on the free left edge, centers close
    assign dy = $signed(SW'(p_y)) - $signed(SW'(h_y));
    assign dd = (dy <<< 1) + $signed(SW'(p_h)) - $signed(SW'(h_h));
    assign ad = dd[SW-1] ? -dd : dd;
    assign mh = (p_h > h_h) ? p_h : h_h;
    assign bonus_hit = (SUMW'(h_x) == SUMW'(p_x) + SUMW'(p_w)) && (ad < $signed(SW'(mh)));

    assign cur_bonus = (state_reg == S_SC_SCAN) ? bonus_reg : BW'(0);
    assign score_now = $signed(SCW'(h_y)) - $signed(SCW'(cur_bonus));
    assign better    = !found_reg || (score_now < best_reg);

    // placement at the top of the winner, left or right aligned
    assign new_x = best_bonus_reg ? k_x
                 : DW'(SUMW'(k_x) + SUMW'(k_w) - SUMW'(w_reg));
    assign g_new = {new_x, k_y, DW'(w_reg), DW'(h_reg)};

    // split of the head entry against the placement
    assign f_r = SUMW'(h_x) + SUMW'(h_w);
    assign f_b = SUMW'(h_y) + SUMW'(h_h);
    assign g_r = SUMW'(g_x) + SUMW'(g_w);
    assign g_b = SUMW'(g_y) + SUMW'(g_h);
    assign ovl = !((f_r <= SUMW'(g_x)) || (SUMW'(h_x) >= g_r) ||
                   (f_b <= SUMW'(g_y)) || (SUMW'(h_y) >= g_b));

    assign piece_ok[0]  = g_r < f_r;
    assign piece_val[0] = {DW'(g_r), h_y, DW'(f_r - g_r), h_h};
    assign piece_ok[1]  = g_b < f_b;
    assign piece_val[1] = {h_x, DW'(g_b), h_w, DW'(f_b - g_b)};
    assign piece_ok[2]  = g_x > h_x;
    assign piece_val[2] = {h_x, h_y, DW'(g_x - h_x), h_h};
    assign piece_ok[3]  = g_y > h_y;
    assign piece_val[3] = {h_x, h_y, h_w, DW'(g_y - h_y)};

    // survivor a encloses candidate b
    assign a_x = fx(sv_rdata);
    assign a_y = fy(sv_rdata);
    assign a_w = fw(sv_rdata);
    assign a_h = fh(sv_rdata);
    assign b_x = fx(cand_reg);
    assign b_y = fy(cand_reg);
    assign b_w = fw(cand_reg);
    assign b_h = fh(cand_reg);
    assign encl = !((b_x < a_x) || (SUMW'(b_x) + SUMW'(b_w) > SUMW'(a_x) + SUMW'(a_w)) ||
                    (b_y < a_y) || (SUMW'(b_y) + SUMW'(b_h) > SUMW'(a_y) + SUMW'(a_h)));

    //------------------------------------------------------------------
    // sequencer: next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((kind == KIND_START) || (placed_count_reg >= PCW'(PLACED_MAX)) ||
                        (rect_width == '0) || (rect_height == '0))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SC_HEAD;
                    end
                end
            end
            S_SC_HEAD:
            begin
                if (at_end)
                begin
                    state_next = S_SC_END;
                end
                else if (active && fits && (placed_count_reg != '0))
                begin
                    state_next = S_SC_SCAN;
                end
            end
            S_SC_SCAN:
            begin
                if (!scan_issue && !pend_reg)
                begin
                    state_next = S_SC_HEAD;
                end
            end
            S_SC_END:
            begin
                state_next = found_reg ? S_SPL_A : S_FINISH;
            end
            S_SPL_A:
            begin
                if (at_end)
                begin
                    state_next = S_SPL_B;
                end
            end
            S_SPL_B:
            begin
                if (at_end)
                begin
                    state_next = S_PR_FETCH;
                end
            end
            S_PR_FETCH:
            begin
                state_next = (i_reg == n_reg) ? S_LD : S_PR_WAIT;
            end
            S_PR_WAIT:
            begin
                state_next = S_PR_SCAN;
            end
            S_PR_SCAN:
            begin
                if (!sv_issue && !pend_reg)
                begin
                    state_next = S_PR_FETCH;
                end
            end
            S_LD:
            begin
                if (!ld_issue && !pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // sequencer: datapath control
    //------------------------------------------------------------------
    always_comb
    begin
        i_next            = i_reg;
        j_next            = j_reg;
        pend_next         = pend_reg;
        live_next         = live_reg;
        bonus_next        = bonus_reg;
        best_next         = best_reg;
        best_bonus_next   = best_bonus_reg;
        found_next        = found_reg;
        pick_next         = pick_reg;
        g_next            = g_reg;
        w_next            = w_reg;
        h_next            = h_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        m_next            = m_reg;
        pc_next           = pc_reg;
        killed_next       = killed_reg;
        cand_next         = cand_reg;
        free_count_next   = free_count_reg;
        placed_count_next = placed_count_reg;
        res_x_next        = res_x_reg;
        res_y_next        = res_y_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_status_next   = out_status_reg;
        chain_shift       = 1'b0;
        chain_set         = 1'b0;
        chain_load        = 1'b0;
        load_val          = '0;
        p_we              = 1'b0;
        sc_we             = 1'b0;
        sc_wdata          = head;
        sv_we             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_status_next = ST_OK;
                    w_next          = rect_width;
                    h_next          = rect_height;
                    i_next          = '0;
                    found_next      = 1'b0;
                    if (kind == KIND_START)
                    begin
                        chain_set         = 1'b1;
                        free_count_next   = FCW'(1);
                        placed_count_next = '0;
                    end
                    else if (placed_count_reg >= PCW'(PLACED_MAX))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if ((rect_width == '0) || (rect_height == '0))
                    begin
                        res_status_next = ST_NOFIT;
                    end
                end
            end
            S_SC_HEAD:
            begin
                if (!at_end)
                begin
                    if (active && fits && (placed_count_reg != '0))
                    begin
                        j_next     = '0;
                        pend_next  = 1'b0;
                        bonus_next = '0;
                    end
                    else
                    begin
                        if (active && fits && better)
                        begin
                            best_next       = score_now;
                            best_bonus_next = 1'b0;
                            pick_next       = head;
                            found_next      = 1'b1;
                        end
                        chain_shift = 1'b1;
                        i_next      = i_reg + NW'(1);
                    end
                end
            end
            S_SC_SCAN:
            begin
                if (scan_issue)
                begin
                    j_next = j_reg + PCW'(1);
                end
                pend_next = scan_issue;
                if (pend_reg && bonus_hit)
                begin
                    bonus_next = bonus_reg + BW'(BONUS_STEP);
                end
                if (!scan_issue && !pend_reg)
                begin
                    if (better)
                    begin
                        best_next       = score_now;
                        best_bonus_next = cur_bonus != '0;
                        pick_next       = head;
                        found_next      = 1'b1;
                    end
                    chain_shift = 1'b1;
                    i_next      = i_reg + NW'(1);
                end
            end
            S_SC_END:
            begin
                if (found_reg)
                begin
                    p_we              = 1'b1;
                    g_next            = g_new;
                    placed_count_next = placed_count_reg + PCW'(1);
                    res_x_next        = POS_W'(new_x);
                    res_y_next        = POS_W'(k_y);
                    i_next            = '0;
                    n_next            = '0;
                end
                else
                begin
                    res_status_next = ST_NOFIT;
                end
            end
            S_SPL_A:
            begin
                // untouched entries keep their order
                if (at_end)
                begin
                    i_next  = '0;
                    pc_next = '0;
                end
                else
                begin
                    if (active && !ovl && (n_reg < NW'(SD)))
                    begin
                        sc_we  = 1'b1;
                        n_next = n_reg + NW'(1);
                    end
                    chain_shift = 1'b1;
                    i_next      = i_reg + NW'(1);
                end
            end
            S_SPL_B:
            begin
                // right, below, left, above remainders, one per cycle
                if (at_end)
                begin
                    i_next = '0;
                    k_next = '0;
                end
                else if (active && ovl)
                begin
                    sc_wdata = piece_val[pc_reg];
                    if (piece_ok[pc_reg] && (n_reg < NW'(SD)))
                    begin
                        sc_we  = 1'b1;
                        n_next = n_reg + NW'(1);
                    end
                    pc_next = pc_reg + 2'd1;
                    if (pc_reg == 2'd3)
                    begin
                        chain_shift = 1'b1;
                        i_next      = i_reg + NW'(1);
                    end
                end
                else
                begin
                    chain_shift = 1'b1;
                    i_next      = i_reg + NW'(1);
                end
            end
            S_PR_FETCH:
            begin
                m_next    = '0;
                pend_next = 1'b0;
            end
            S_PR_WAIT:
            begin
                cand_next   = sc_rdata;
                m_next      = '0;
                killed_next = 1'b0;
                pend_next   = 1'b0;
            end
            S_PR_SCAN:
            begin
                // candidate survives unless an earlier survivor encloses it
                if (sv_issue)
                begin
                    m_next = m_reg + NW'(1);
                end
                pend_next = sv_issue;
                if (pend_reg && encl)
                begin
                    killed_next = 1'b1;
                end
                if (!sv_issue && !pend_reg)
                begin
                    if (!killed_reg)
                    begin
                        sv_we  = 1'b1;
                        k_next = k_reg + NW'(1);
                    end
                    i_next = i_reg + NW'(1);
                end
            end
            S_LD:
            begin
                // shift survivors into the chain, zero fill past the count
                if (ld_issue)
                begin
                    m_next = m_reg + NW'(1);
                end
                pend_next = ld_issue;
                live_next = m_reg < k_reg;
                if (pend_reg)
                begin
                    chain_shift = 1'b1;
                    chain_load  = 1'b1;
                    load_val    = live_reg ? sv_rdata : '0;
                end
                if (!ld_issue && !pend_reg)
                begin
                    if (k_reg > NW'(FREE_MAX))
                    begin
                        free_count_next = FCW'(FREE_MAX);
                        res_status_next = ST_DROP;
                    end
                    else
                    begin
                        free_count_next = FCW'(k_reg);
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // register update
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            pend_reg         <= 1'b0;
            live_reg         <= 1'b0;
            bonus_reg        <= '0;
            found_reg        <= 1'b0;
            best_bonus_reg   <= 1'b0;
            n_reg            <= '0;
            k_reg            <= '0;
            m_reg            <= '0;
            pc_reg           <= '0;
            killed_reg       <= 1'b0;
            free_count_reg   <= FCW'(1);
            placed_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            pend_reg         <= pend_next;
            live_reg         <= live_next;
            bonus_reg        <= bonus_next;
            found_reg        <= found_next;
            best_bonus_reg   <= best_bonus_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            m_reg            <= m_next;
            pc_reg           <= pc_next;
            killed_reg       <= killed_next;
            free_count_reg   <= free_count_next;
            placed_count_reg <= placed_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        pick_reg       <= pick_next;
        g_reg          <= g_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        cand_reg       <= cand_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
    end

    // configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg  <= BIN_RESET;
            bin_height_reg <= BIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIN_WIDTH:  bin_width_reg  <= cfg_data;
                REG_BIN_HEIGHT: bin_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign placed_x  = out_x_reg;
    assign placed_y  = out_y_reg;
    assign status    = out_status_reg;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= FCW'(FREE_MAX))
        else $error("free count past capacity");

    a_placed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        placed_count_reg <= PCW'(PLACED_MAX))
        else $error("placed count past capacity");

    a_scratch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg <= NW'(SD)) && (k_reg <= n_reg || state_reg == S_PR_FETCH ||
         state_reg == S_SPL_A || state_reg == S_SPL_B || state_reg == S_IDLE ||
         state_reg == S_FINISH || state_reg == S_SC_HEAD || state_reg == S_SC_SCAN ||
         state_reg == S_SC_END || state_reg == S_PR_WAIT || state_reg == S_PR_SCAN ||
         state_reg == S_LD))
        else $error("scratch count past capacity");

    a_beat_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result beat without finished item");

endmodule

FILE: sim/maxrects_rectangle_placer_tb.sv
module maxrects_rectangle_placer_tb;
    import maxr_pkg::*;

    localparam int FREE_MAX   = FREE_MAX_DEF;
    localparam int PLACED_MAX = PLACED_MAX_DEF;
    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int PIECE_MAX  = 4 * FREE_MAX;
    localparam int CYCLE_LIMIT = 100000000;
    // quiet cycles after the last result, before a register write or the end
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } box_t;

    typedef struct packed {
        logic             kind;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [STATUS_W-1:0] st;
    } spot_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [DIM_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [DIM_W-1:0]    rect_width;
    logic [DIM_W-1:0]    rect_height;
    logic                out_valid;
    logic                out_stall;
    logic [POS_W-1:0]    placed_x;
    logic [POS_W-1:0]    placed_y;
    logic [STATUS_W-1:0] status;

    maxrects_rectangle_placer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .placed_x   (placed_x),
        .placed_y   (placed_y),
        .status     (status)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the packer state
    // ---------------------------------------------------------------
    int   bin_w_sh;
    int   bin_h_sh;
    box_t free_sh[FREE_MAX];
    int   free_n;
    box_t used_sh[PLACED_MAX];
    int   used_n;

    req_t  pending_reqs[$];
    spot_t expected_spots[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatches;
    int  cycle;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int clip_dim(input int v);
        int lim;
        begin
            lim = 1 << COORD_BITS;
            return (v > lim) ? lim : v;
        end
    endfunction

    function automatic bit boxes_touch(input box_t a, input box_t b);
        return !((a.x + a.w <= b.x) || (a.x >= b.x + b.w) ||
                 (a.y + a.h <= b.y) || (a.y >= b.y + b.h));
    endfunction

    function automatic bit box_holds(input box_t a, input box_t b);
        return !((b.x < a.x) || (b.x + b.w > a.x + a.w) ||
                 (b.y < a.y) || (b.y + b.h > a.y + a.h));
    endfunction

    function automatic void empty_bin();
        begin
            free_sh[0].x = 0;
            free_sh[0].y = 0;
            free_sh[0].w = clip_dim(bin_w_sh);
            free_sh[0].h = clip_dim(bin_h_sh);
            free_n = 1;
            used_n = 0;
        end
    endfunction

    function automatic void add_piece(inout box_t pcs[PIECE_MAX], inout int n,
                                      input int x, input int y, input int w, input int h);
        begin
            if (n < PIECE_MAX)
            begin
                pcs[n].x = x;
                pcs[n].y = y;
                pcs[n].w = w;
                pcs[n].h = h;
                n++;
            end
        end
    endfunction

    // Works out the spot for one request and updates the shadow lists.
    function automatic spot_t place_spot(input req_t r);
        spot_t s;
        box_t  pcs[PIECE_MAX];
        bit    keep[PIECE_MAX];
        box_t  f;
        box_t  p;
        box_t  g;
        int    w;
        int    h;
        int    best;
        int    best_bonus;
        int    pick;
        bit    found;
        int    bonus;
        int    score;
        int    d;
        int    mh;
        int    n;
        int    k;
        begin
            s = '0;
            w = r.w;
            h = r.h;
            best = 0;
            best_bonus = 0;
            pick = 0;
            found = 1'b0;
            if (r.kind == KIND_START)
            begin
                empty_bin();
                return s;
            end
            if (used_n >= PLACED_MAX)
            begin
                s.st = ST_FULL;
                return s;
            end
            if (w == 0 || h == 0)
            begin
                s.st = ST_NOFIT;
                return s;
            end
            for (int i = 0; i < free_n; i++)
            begin
                f = free_sh[i];
                if (f.w < w || f.h < h)
                    continue;
                bonus = 0;
                for (int j = 0; j < used_n; j++)
                begin
                    p = used_sh[j];
                    d = (p.y - f.y) * 2 + p.h - f.h;
                    if (d < 0)
                        d = -d;
                    mh = (p.h > f.h) ? p.h : f.h;
                    if (f.x == p.x + p.w && d < mh)
                        bonus += BONUS_STEP;
                end
                score = f.y - bonus;
                if (!found || score < best)
                begin
                    best = score;
                    best_bonus = bonus;
                    pick = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                s.st = ST_NOFIT;
                return s;
            end
            g.y = free_sh[pick].y;
            g.w = w;
            g.h = h;
            g.x = (best_bonus != 0) ? free_sh[pick].x
                                    : free_sh[pick].x + free_sh[pick].w - w;
            used_sh[used_n] = g;
            used_n++;
            n = 0;
            for (int i = 0; i < free_n; i++)
                if (!boxes_touch(free_sh[i], g))
                begin
                    pcs[n] = free_sh[i];
                    n++;
                end
            for (int i = 0; i < free_n; i++)
            begin
                f = free_sh[i];
                if (!boxes_touch(f, g))
                    continue;
                if (g.x + g.w < f.x + f.w)
                    add_piece(pcs, n, g.x + g.w, f.y, f.x + f.w - (g.x + g.w), f.h);
                if (g.y + g.h < f.y + f.h)
                    add_piece(pcs, n, f.x, g.y + g.h, f.w, f.y + f.h - (g.y + g.h));
                if (g.x > f.x)
                    add_piece(pcs, n, f.x, f.y, g.x - f.x, f.h);
                if (g.y > f.y)
                    add_piece(pcs, n, f.x, f.y, f.w, g.y - f.y);
            end
            for (int i = 0; i < n; i++)
                keep[i] = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (!keep[i])
                    continue;
                for (int j = i + 1; j < n; j++)
                    if (keep[j] && box_holds(pcs[i], pcs[j]))
                        keep[j] = 1'b0;
            end
            k = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!keep[i])
                    continue;
                if (k < FREE_MAX)
                begin
                    free_sh[k] = pcs[i];
                    k++;
                end
                else
                    s.st = ST_DROP;
            end
            free_n = k;
            s.x = g.x[POS_W-1:0];
            s.y = g.y[POS_W-1:0];
            return s;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents queued requests, random gaps between beats
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            kind        <= KIND_START;
            rect_width  <= '0;
            rect_height <= '0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                // previous beat taken (or none up): pick the next one
                if (in_valid)
                    void'(pending_reqs.pop_front());
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    kind        <= pending_reqs[0].kind;
                    rect_width  <= pending_reqs[0].w;
                    rect_height <= pending_reqs[0].h;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // prediction happens when the beat is accepted
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_spots.push_back(place_spot('{kind, rect_width, rect_height}));
    end

    // ---------------------------------------------------------------
    // Monitor: random stall, compares every result beat in order
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_spots.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%0d y=%0d st=%0d",
                                 placed_x, placed_y, status);
                end
                else
                begin
                    if (placed_x !== expected_spots[0].x ||
                        placed_y !== expected_spots[0].y ||
                        status !== expected_spots[0].st)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
                                     expected_spots[0].x, expected_spots[0].y,
                                     expected_spots[0].st, placed_x, placed_y, status);
                    end
                    void'(expected_spots.pop_front());
                end
            end
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_req(input logic k, input int w, input int h);
        req_t r;
        begin
            r.kind = k;
            r.w = w[DIM_W-1:0];
            r.h = h[DIM_W-1:0];
            pending_reqs.push_back(r);
        end
    endtask

    // wait for the block to drain, then let it settle
    task automatic drain();
        begin
            while (pending_reqs.size() != 0 || in_valid || expected_spots.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input int v);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v[DIM_W-1:0];
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == REG_BIN_WIDTH)
                bin_w_sh = v & 13'h1fff;
            else
                bin_h_sh = v & 13'h1fff;
        end
    endtask

    // mostly small pieces so the bin fills and the tables hit their limits
    function automatic int rand_dim(input int bin);
        int r;
        begin
            r = $urandom_range(99, 0);
            if (r < 3)
                return 0;
            if (r < 6)
                return $urandom_range(8191, 0);
            if (r < 10)
                return $urandom_range(4096, 1);
            if (bin < 2)
                return 1;
            return $urandom_range((bin > 16) ? bin / 6 : bin, 1);
        end
    endfunction

    task automatic random_phase(input int count, input int bw, input int bh);
        begin
            queue_req(KIND_START, $urandom_range(8191, 0), $urandom_range(8191, 0));
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(99, 0) < 3)
                    queue_req(KIND_START, $urandom_range(8191, 0),
                              $urandom_range(8191, 0));
                else
                    queue_req(KIND_PLACE, rand_dim(bw), rand_dim(bh));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BIN_WIDTH;
        cfg_data = '0;
        out_stall = 1'b0;
        in_valid = 1'b0;
        kind = KIND_START;
        rect_width = '0;
        rect_height = '0;
        mismatches = 0;
        cycle = 0;
        send_idle_pct = 25;
        recv_idle_pct = 48;
        bin_w_sh = BIN_RESET;
        bin_h_sh = BIN_RESET;
        empty_bin();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default bin, extremes, no-fit, zero size, start
        queue_req(KIND_PLACE, 4096, 4096);
        queue_req(KIND_PLACE, 1, 1);
        queue_req(KIND_START, 8191, 8191);
        queue_req(KIND_PLACE, 0, 5);
        queue_req(KIND_PLACE, 5, 0);
        queue_req(KIND_PLACE, 8191, 8191);
        queue_req(KIND_PLACE, 4097, 1);
        queue_req(KIND_PLACE, 100, 200);
        queue_req(KIND_PLACE, 100, 200);
        queue_req(KIND_PLACE, 3996, 50);
        queue_req(KIND_PLACE, 1, 4096);
        drain();

        // tiny bin: placed table fills up
        write_reg(REG_BIN_WIDTH, 64);
        write_reg(REG_BIN_HEIGHT, 2);
        queue_req(KIND_START, 0, 0);
        for (int i = 0; i < 70; i++)
            queue_req(KIND_PLACE, 1, 1);
        drain();

        // zero bin and oversized bin
        write_reg(REG_BIN_WIDTH, 0);
        queue_req(KIND_START, 0, 0);
        queue_req(KIND_PLACE, 1, 1);
        drain();
        write_reg(REG_BIN_WIDTH, 8191);
        write_reg(REG_BIN_HEIGHT, 8191);
        queue_req(KIND_START, 0, 0);
        queue_req(KIND_PLACE, 4096, 1);
        drain();

        random_phase(250, 4096, 4096);
        drain();
        send_idle_pct = 48;
        recv_idle_pct = 25;
        write_reg(REG_BIN_WIDTH, 1);
        write_reg(REG_BIN_HEIGHT, 4096);
        random_phase(40, 1, 4096);
        drain();
        write_reg(REG_BIN_WIDTH, 300);
        write_reg(REG_BIN_HEIGHT, 200);
        random_phase(210, 300, 200);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_BIN_WIDTH, 4096);
        write_reg(REG_BIN_HEIGHT, 1000);
        random_phase(170, 4096, 1000);
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
